/* sv/index_ring_node_allocator_assert.svh */
// ----------------------------------------------------------------------------
// index ring node allocator assertion macros
// shorthand for clocked assertions on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef INDEX_RING_NODE_ALLOCATOR_ASSERT_SVH
`define INDEX_RING_NODE_ALLOCATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IRNA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define IRNA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// expression holds at every edge out of reset
`define IRNA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

/* sv/irna_pkg.sv */
// ----------------------------------------------------------------------------
// irna_pkg
// shared widths, operation codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package irna_pkg;

    localparam int IDX_W  = 10;
    localparam int TAG_W  = 32;
    // wide enough to hold any node count in range
    localparam int WIDE_W = 17;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_LINK    = 2'd1;
    localparam logic [1:0] OP_UNLINK  = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    // result status codes
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic latch_in;
        logic scan_start;
        logic scan_step;
        logic alloc_write;
        logic alloc_full;
        logic link_w1;
        logic link_w2;
        logic unl_w1;
        logic unl_w2;
        logic rel_write;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       node_ok;
        logic       pair_ok;
        logic       free_hit;
        logic       scan_last;
        logic       clear_last;
    } stat_t;

endpackage

/* sv/irna_ram.sv */
// ----------------------------------------------------------------------------
// irna_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module irna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/irna_ctrl.sv */
// ----------------------------------------------------------------------------
// irna_ctrl
// operation sequencer: clearing pass, dispatch, scan, link steps, result beat
// ----------------------------------------------------------------------------
`include "index_ring_node_allocator_assert.svh"

module irna_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  irna_pkg::stat_t stat,
    output irna_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_LINK1    = 4'd4;
    localparam logic [3:0] S_LINK2    = 4'd5;
    localparam logic [3:0] S_UNL1     = 4'd6;
    localparam logic [3:0] S_UNL2     = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.op)
                    irna_pkg::OP_ALLOC:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    irna_pkg::OP_LINK:
                    begin
                        state_next = stat.pair_ok ? S_LINK1 : S_DONE;
                    end
                    irna_pkg::OP_UNLINK:
                    begin
                        state_next = stat.node_ok ? S_UNL1 : S_DONE;
                    end
                    default:
                    begin
                        cmd.rel_write = stat.node_ok;
                        state_next    = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                priority if (stat.free_hit)
                begin
                    cmd.alloc_write = 1'b1;
                    state_next      = S_DONE;
                end
                else if (stat.scan_last)
                begin
                    cmd.alloc_full = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_LINK1:
            begin
                cmd.link_w1 = 1'b1;
                state_next  = S_LINK2;
            end
            S_LINK2:
            begin
                cmd.link_w2 = 1'b1;
                state_next  = S_DONE;
            end
            S_UNL1:
            begin
                cmd.unl_w1 = 1'b1;
                state_next = S_UNL2;
            end
            S_UNL2:
            begin
                cmd.unl_w2 = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // the output register frees up when empty or when its beat is taken
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `IRNA_ASSERT_NXT(a_accept_dispatch, in_valid && !in_stall, state_reg == S_DISPATCH, "accepted beat did not reach dispatch")
    `IRNA_ASSERT_IMP(a_result_from_done, $rose(out_valid_reg), $past(state_reg) == S_DONE, "result beat raised outside done")
    `IRNA_ASSERT_IMP(a_clear_complete, $past(state_reg) == S_CLEAR && state_reg != S_CLEAR, $past(stat.clear_last), "clearing pass ended early")

endmodule

/* sv/irna_dpath.sv */
// ----------------------------------------------------------------------------
// irna_dpath
// node tables, scan pointer, operand and result registers
// ----------------------------------------------------------------------------
`include "index_ring_node_allocator_assert.svh"

module irna_dpath #(
    parameter int NODES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  irna_pkg::cmd_t              cmd,
    output irna_pkg::stat_t             stat,
    input  logic [1:0]                  operation,
    input  logic [irna_pkg::IDX_W-1:0]  node_index,
    input  logic [irna_pkg::IDX_W-1:0]  root_index,
    input  logic [irna_pkg::TAG_W-1:0]  payload,
    output logic [irna_pkg::IDX_W-1:0]  result_index,
    output logic                        status
);

    localparam int IW = $clog2(NODES);
    localparam logic [irna_pkg::WIDE_W-1:0] NODES_W = irna_pkg::WIDE_W'(NODES);
    localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);
    localparam logic [IW-1:0] SCAN_END = IW'(NODES - 2);

    logic [1:0]                 op_reg;
    logic [irna_pkg::IDX_W-1:0] node_reg;
    logic [irna_pkg::IDX_W-1:0] root_reg;
    logic [irna_pkg::TAG_W-1:0] tag_reg;
    logic [IW-1:0]              cur_reg;
    logic [IW-1:0]              cur_next;
    logic [IW-1:0]              cnt_reg;
    logic [IW-1:0]              cnt_next;
    logic [IW-1:0]              scan_pos_reg;
    logic [IW-1:0]              scan_pos_next;
    logic [IW-1:0]              clr_cnt_reg;
    logic [IW-1:0]              clr_cnt_next;
    logic [IW-1:0]              after_reg;
    logic [irna_pkg::IDX_W-1:0] res_index_reg;
    logic [irna_pkg::IDX_W-1:0] res_index_next;
    logic                       res_status_reg;
    logic                       res_status_next;
    logic [irna_pkg::IDX_W-1:0] out_index_reg;
    logic                       out_status_reg;

    logic [irna_pkg::WIDE_W-1:0] node_wide;
    logic [irna_pkg::WIDE_W-1:0] root_wide;
    logic [irna_pkg::WIDE_W-1:0] cur_wide;
    logic [irna_pkg::WIDE_W-1:0] pos_wide;
    logic [IW-1:0]               node_addr;
    logic [IW-1:0]               root_addr;
    logic [IW-1:0]               nxt_cur;

    logic                       pay_we;
    logic [IW-1:0]              pay_waddr;
    logic [irna_pkg::TAG_W-1:0] pay_wdata;
    logic [IW-1:0]              pay_raddr;
    logic [irna_pkg::TAG_W-1:0] pay_rdata;

    logic          lnk_we;
    logic [IW-1:0] nxt_waddr;
    logic [IW-1:0] nxt_wdata;
    logic [IW-1:0] nxt_raddr;
    logic [IW-1:0] nxt_rdata;
    logic [IW-1:0] prv_waddr;
    logic [IW-1:0] prv_wdata;
    logic [IW-1:0] prv_rdata;

    function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] idx);
        logic [IW-1:0] res;
        res = (idx == LAST_IDX) ? IW'(1) : IW'(idx + IW'(1));
        return res;
    endfunction

    assign node_wide = {{(irna_pkg::WIDE_W - irna_pkg::IDX_W){1'b0}}, node_reg};
    assign root_wide = {{(irna_pkg::WIDE_W - irna_pkg::IDX_W){1'b0}}, root_reg};
    assign cur_wide  = {{(irna_pkg::WIDE_W - IW){1'b0}}, cur_reg};
    assign pos_wide  = {{(irna_pkg::WIDE_W - IW){1'b0}}, scan_pos_reg};
    assign node_addr = node_wide[IW-1:0];
    assign root_addr = root_wide[IW-1:0];
    assign nxt_cur   = step_idx(cur_reg);

    assign stat.op         = op_reg;
    assign stat.node_ok    = (node_reg != '0) && (node_wide < NODES_W);
    assign stat.pair_ok    = stat.node_ok && (root_reg != '0) && (root_wide < NODES_W);
    assign stat.free_hit   = (pay_rdata == '0);
    assign stat.scan_last  = (cnt_reg == SCAN_END);
    assign stat.clear_last = (clr_cnt_reg == LAST_IDX);

    // payload table: clearing sweep, allocate store, release clear
    always_comb
    begin
        pay_we    = cmd.clr_step || cmd.alloc_write || cmd.rel_write;
        pay_wdata = cmd.alloc_write ? tag_reg : '0;
        priority if (cmd.clr_step)
        begin
            pay_waddr = clr_cnt_reg;
        end
        else if (cmd.alloc_write)
        begin
            pay_waddr = cur_reg;
        end
        else
        begin
            pay_waddr = node_addr;
        end
        // scan reads one entry ahead of the one being checked
        pay_raddr = cmd.scan_start ? scan_pos_reg : nxt_cur;
    end

    // link tables: reads stay on the operand so data is ready after dispatch
    always_comb
    begin
        lnk_we    = cmd.link_w1 || cmd.link_w2 || cmd.unl_w1 || cmd.unl_w2 || cmd.alloc_write;
        nxt_raddr = (op_reg == irna_pkg::OP_LINK) ? root_addr : node_addr;
        priority if (cmd.link_w1)
        begin
            nxt_waddr = node_addr;
            nxt_wdata = nxt_rdata;
            prv_waddr = node_addr;
            prv_wdata = root_addr;
        end
        else if (cmd.link_w2)
        begin
            nxt_waddr = root_addr;
            nxt_wdata = node_addr;
            prv_waddr = after_reg;
            prv_wdata = node_addr;
        end
        else if (cmd.unl_w1)
        begin
            nxt_waddr = prv_rdata;
            nxt_wdata = nxt_rdata;
            prv_waddr = nxt_rdata;
            prv_wdata = prv_rdata;
        end
        else if (cmd.unl_w2)
        begin
            nxt_waddr = node_addr;
            nxt_wdata = node_addr;
            prv_waddr = node_addr;
            prv_wdata = node_addr;
        end
        else
        begin
            nxt_waddr = cur_reg;
            nxt_wdata = cur_reg;
            prv_waddr = cur_reg;
            prv_wdata = cur_reg;
        end
    end

    always_comb
    begin
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        scan_pos_next   = scan_pos_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        if (cmd.clr_step)
        begin
            clr_cnt_next = IW'(clr_cnt_reg + IW'(1));
        end
        if (cmd.latch_in)
        begin
            res_index_next  = '0;
            res_status_next = irna_pkg::ST_DONE;
        end
        if (cmd.scan_start)
        begin
            cur_next = scan_pos_reg;
            cnt_next = '0;
        end
        if (cmd.scan_step)
        begin
            cur_next = nxt_cur;
            cnt_next = IW'(cnt_reg + IW'(1));
        end
        if (cmd.alloc_write)
        begin
            scan_pos_next   = nxt_cur;
            res_index_next  = cur_wide[irna_pkg::IDX_W-1:0];
            res_status_next = irna_pkg::ST_DONE;
        end
        if (cmd.alloc_full)
        begin
            res_index_next  = '0;
            res_status_next = irna_pkg::ST_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg <= IW'(1);
            clr_cnt_reg  <= '0;
        end
        else
        begin
            scan_pos_reg <= scan_pos_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg   <= operation;
            node_reg <= node_index;
            root_reg <= root_index;
            tag_reg  <= payload;
        end
        if (cmd.link_w1)
        begin
            after_reg <= nxt_rdata;
        end
        if (cmd.load_out)
        begin
            out_index_reg  <= res_index_reg;
            out_status_reg <= res_status_reg;
        end
        cur_reg        <= cur_next;
        cnt_reg        <= cnt_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
    end

    irna_ram #(
        .WIDTH (irna_pkg::TAG_W),
        .DEPTH (NODES)
    ) u_payload_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    irna_ram #(
        .WIDTH (IW),
        .DEPTH (NODES)
    ) u_next_ram (
        .clk   (clk),
        .we    (lnk_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    irna_ram #(
        .WIDTH (IW),
        .DEPTH (NODES)
    ) u_prev_ram (
        .clk   (clk),
        .we    (lnk_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (node_addr),
        .rdata (prv_rdata)
    );

    assign result_index = out_index_reg;
    assign status       = out_status_reg;

    `IRNA_ASSERT_ALWAYS(a_scan_pos_nonzero, scan_pos_reg != '0, "scan position reached entry zero")
    `IRNA_ASSERT_ALWAYS(a_scan_pos_range, pos_wide < NODES_W, "scan position beyond table")
    `IRNA_ASSERT_NXT(a_full_result, cmd.alloc_full, res_status_reg && (res_index_reg == '0), "full allocate left a nonzero index")

endmodule

/* sv/index_ring_node_allocator.sv */
// ----------------------------------------------------------------------------
// index_ring_node_allocator
// table of ring nodes with next-fit allocate, link, unlink and release
// ----------------------------------------------------------------------------
// After reset the block clears every entry of the payload table and holds
// in_stall high meanwhile. One operation is in flight at a time and each
// accepted beat produces one result beat. Link and unlink do one read of the
// link tables, then two writes on their single write ports, and allocate
// checks 1 up to NODES-1 entries: the scan checks one payload entry per cycle
// through the payload table's read port. A new beat is taken while the
// previous result still waits in the output register.
module index_ring_node_allocator #(
    parameter int NODES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  operation,
    input  logic [irna_pkg::IDX_W-1:0]  node_index,
    input  logic [irna_pkg::IDX_W-1:0]  root_index,
    input  logic [irna_pkg::TAG_W-1:0]  payload,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [irna_pkg::IDX_W-1:0]  result_index,
    output logic                        status
);

    irna_pkg::cmd_t  cmd;
    irna_pkg::stat_t stat;

    irna_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    irna_dpath #(
        .NODES (NODES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (operation),
        .node_index   (node_index),
        .root_index   (root_index),
        .payload      (payload),
        .result_index (result_index),
        .status       (status)
    );

endmodule

/* tb/tb_index_ring_node_allocator.sv */
// ----------------------------------------------------------------------------
// tb_index_ring_node_allocator
// self-checking bench: a shadow of the node table predicts every result beat,
// directed and random operation streams run with random idling on both sides
// ----------------------------------------------------------------------------
module tb_index_ring_node_allocator;

    localparam int  NODES      = 1024;
    localparam int  IDLE_LIMIT = 5000;

    typedef struct packed {
        logic [irna_pkg::IDX_W-1:0] idx;
        logic                       st;
    } result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 operation;
    logic [irna_pkg::IDX_W-1:0] node_index;
    logic [irna_pkg::IDX_W-1:0] root_index;
    logic [irna_pkg::TAG_W-1:0] payload;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [irna_pkg::IDX_W-1:0] result_index;
    logic                       status;

    index_ring_node_allocator #(.NODES(NODES)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .node_index   (node_index),
        .root_index   (root_index),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_index (result_index),
        .status       (status)
    );

    // shadow of the node table
    logic [irna_pkg::TAG_W-1:0] tag_mem [NODES];
    int                         nxt_mem [NODES];
    int                         prv_mem [NODES];
    bit                         links_ok [NODES];
    int                         scan_pos;

    result_t pending_results [$];

    int  errors = 0;
    int  n_items = 0;
    int  n_alloc = 0;
    int  n_full = 0;
    int  n_link = 0;
    int  n_unlink = 0;
    int  n_release = 0;
    int  cyc = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;
    logic quiet;

    assign quiet = ((cyc / 300) % 4) == 3;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cyc <= cyc + 1;

    function automatic int wrap_next(input int pos);
        return (pos + 1 < NODES) ? pos + 1 : 1;
    endfunction

    function automatic bit usable_idx(input int i);
        return i != 0 && i < NODES;
    endfunction

    // applies one operation to the shadow table and returns the expected beat
    function automatic result_t table_apply(input logic [1:0] op, input int node,
                                            input int root,
                                            input logic [irna_pkg::TAG_W-1:0] tag);
        result_t r;
        int      pos;
        int      k;
        int      after;
        int      n;
        int      p;
        bit      found;
        r.idx = '0;
        r.st  = irna_pkg::ST_DONE;
        case (op)
            irna_pkg::OP_ALLOC:
            begin
                pos = scan_pos;
                if (pos == 0 || pos >= NODES)
                    pos = 1;
                found = 1'b0;
                for (k = 0; k + 1 < NODES && !found; k++)
                begin
                    if (tag_mem[pos] == '0)
                    begin
                        found         = 1'b1;
                        tag_mem[pos]  = tag;
                        nxt_mem[pos]  = pos;
                        prv_mem[pos]  = pos;
                        links_ok[pos] = 1'b1;
                        r.idx         = pos[irna_pkg::IDX_W-1:0];
                        scan_pos      = wrap_next(pos);
                    end
                    else
                        pos = wrap_next(pos);
                end
                if (!found)
                    r.st = irna_pkg::ST_FULL;
            end
            irna_pkg::OP_LINK:
            begin
                if (usable_idx(node) && usable_idx(root))
                begin
                    after          = (nxt_mem[root] < NODES) ? nxt_mem[root] : 0;
                    prv_mem[node]  = root;
                    nxt_mem[node]  = after;
                    nxt_mem[root]  = node;
                    prv_mem[after] = node;
                    links_ok[node] = 1'b1;
                end
            end
            irna_pkg::OP_UNLINK:
            begin
                if (usable_idx(node))
                begin
                    n = (nxt_mem[node] < NODES) ? nxt_mem[node] : 0;
                    p = (prv_mem[node] < NODES) ? prv_mem[node] : 0;
                    prv_mem[n]    = p;
                    nxt_mem[p]    = n;
                    nxt_mem[node] = node;
                    prv_mem[node] = node;
                end
            end
            default:
            begin
                if (usable_idx(node))
                    tag_mem[node] = '0;
            end
        endcase
        return r;
    endfunction

    // random entry that holds a tag (want_busy) or has its links written
    function automatic int pick_index(input bit want_busy);
        int s;
        int i;
        int k;
        int hit;
        s   = $urandom_range(1, NODES - 1);
        hit = 0;
        for (k = 0; k < NODES - 1 && hit == 0; k++)
        begin
            i = 1 + ((s - 1 + k) % (NODES - 1));
            if (want_busy ? (tag_mem[i] != '0) : links_ok[i])
                hit = i;
        end
        return hit;
    endfunction

    function automatic int free_count();
        int i;
        int c;
        c = 0;
        for (i = 1; i < NODES; i++)
            if (tag_mem[i] == '0)
                c++;
        return c;
    endfunction

    task automatic send_beat(input logic [1:0] op, input int node, input int root,
                             input logic [irna_pkg::TAG_W-1:0] tag);
        result_t r;
        if (idle_on && !quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        node_index <= node[irna_pkg::IDX_W-1:0];
        root_index <= root[irna_pkg::IDX_W-1:0];
        payload    <= tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = table_apply(op, node[irna_pkg::IDX_W-1:0], root[irna_pkg::IDX_W-1:0], tag);
        pending_results.push_back(r);
        n_items++;
        case (op)
            irna_pkg::OP_ALLOC:
            begin
                n_alloc++;
                if (r.st == irna_pkg::ST_FULL)
                    n_full++;
            end
            irna_pkg::OP_LINK:   n_link++;
            irna_pkg::OP_UNLINK: n_unlink++;
            default:             n_release++;
        endcase
    endtask

    // sender holds off until every outstanding result beat is back
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, got index %0d status %0d",
                         $time, result_index, status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_index !== want.idx)
                begin
                    errors++;
                    $display("%0t: result_index mismatch, expected %0d, got %0d",
                             $time, want.idx, result_index);
                end
                if (status !== want.st)
                begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.st, status);
                end
            end
        end
    end

    // receiver stalls in short random bursts
    always @(posedge clk)
    begin
        if (!idle_on || quiet)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 4);
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_directed();
        send_beat(irna_pkg::OP_ALLOC, 0, 0, 32'hFFFF_FFFF);
        send_beat(irna_pkg::OP_ALLOC, 0, 0, 32'h0000_0001);
        // zero tag leaves the node free
        send_beat(irna_pkg::OP_ALLOC, 0, 0, 32'h0000_0000);
        send_beat(irna_pkg::OP_ALLOC, 1023, 1023, 32'h8000_0000);
        send_beat(irna_pkg::OP_ALLOC, 0, 0, 32'h0000_0007);
        send_beat(irna_pkg::OP_LINK, 2, 1, 32'h0);
        send_beat(irna_pkg::OP_LINK, 4, 1, 32'h0);
        send_beat(irna_pkg::OP_LINK, 1023, 2, 32'h0);
        send_beat(irna_pkg::OP_LINK, 5, 1023, 32'hFFFF_FFFF);
        send_beat(irna_pkg::OP_UNLINK, 2, 0, 32'h0);
        send_beat(irna_pkg::OP_RELEASE, 2, 0, 32'h0);
        // node linked after itself
        send_beat(irna_pkg::OP_LINK, 1, 1, 32'h0);
        send_beat(irna_pkg::OP_UNLINK, 1023, 1023, 32'h0);
        send_beat(irna_pkg::OP_RELEASE, 1023, 0, 32'h0);
        // entry 0 as node or root is ignored
        send_beat(irna_pkg::OP_RELEASE, 0, 1023, 32'h0);
        send_beat(irna_pkg::OP_UNLINK, 0, 1023, 32'h0);
        send_beat(irna_pkg::OP_LINK, 0, 1, 32'h0);
        send_beat(irna_pkg::OP_LINK, 1, 0, 32'h0);
        send_beat(irna_pkg::OP_LINK, 0, 0, 32'h0);
        send_beat(irna_pkg::OP_ALLOC, 0, 0, 32'h5A5A_5A5A);
        send_beat(irna_pkg::OP_RELEASE, 1, 0, 32'h0);
        send_beat(irna_pkg::OP_UNLINK, 4, 0, 32'h0);
        send_beat(irna_pkg::OP_RELEASE, 4, 0, 32'h0);
        send_beat(irna_pkg::OP_ALLOC, 0, 0, 32'h1234_5678);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_beat(irna_pkg::OP_LINK, 0, $urandom_range(0, 1023), $urandom);
            1: send_beat(irna_pkg::OP_LINK, $urandom_range(1, 1023), 0, $urandom);
            2: send_beat(irna_pkg::OP_UNLINK, 0, $urandom_range(0, 1023), $urandom);
            default: send_beat(irna_pkg::OP_RELEASE, 0, $urandom_range(0, 1023), $urandom);
        endcase
    endtask

    task automatic test_random_mix(input int count);
        int i;
        int r;
        int node;
        int root;
        logic [irna_pkg::TAG_W-1:0] tag;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 149) == 0)
                wait_drain();
            if (r < 30)
            begin
                tag = ($urandom_range(0, 39) == 0) ? '0 : $urandom;
                send_beat(irna_pkg::OP_ALLOC, $urandom_range(0, 1023),
                          $urandom_range(0, 1023), tag);
            end
            else if (r < 50)
            begin
                node = ($urandom_range(0, 9) < 7) ? pick_index(1'b1) : $urandom_range(1, 1023);
                if (node == 0)
                    node = $urandom_range(1, 1023);
                // on a coin flip, splice a linked node out first so that it then joins one ring only
                if (links_ok[node] && $urandom_range(0, 1) == 0)
                    send_beat(irna_pkg::OP_UNLINK, node, $urandom_range(0, 1023), $urandom);
                root = pick_index(1'b0);
                send_beat(irna_pkg::OP_LINK, node, root, $urandom);
            end
            else if (r < 65)
                send_beat(irna_pkg::OP_UNLINK, pick_index(1'b0), $urandom_range(0, 1023),
                          $urandom);
            else if (r < 85)
            begin
                node = pick_index(1'b1);
                if (node != 0 && links_ok[node] && $urandom_range(0, 1) == 0)
                    send_beat(irna_pkg::OP_UNLINK, node, $urandom_range(0, 1023), $urandom);
                send_beat(irna_pkg::OP_RELEASE, node, $urandom_range(0, 1023), $urandom);
            end
            else if (r < 93)
                send_beat(irna_pkg::OP_RELEASE, $urandom_range(0, 1023),
                          $urandom_range(0, 1023), $urandom);
            else
                send_noise();
        end
    endtask

    task automatic test_table_full();
        int i;
        logic [irna_pkg::TAG_W-1:0] tag;
        while (free_count() > 0)
        begin
            tag = $urandom;
            if (tag == '0)
                tag = 32'h1;
            send_beat(irna_pkg::OP_ALLOC, $urandom_range(0, 1023),
                      $urandom_range(0, 1023), tag);
        end
        send_beat(irna_pkg::OP_ALLOC, 0, 0, $urandom);
        send_beat(irna_pkg::OP_ALLOC, 1023, 1023, $urandom);
        // three holes, then next-fit may have to wrap to find them
        for (i = 0; i < 3; i++)
            send_beat(irna_pkg::OP_RELEASE, pick_index(1'b1), 0, $urandom);
        for (i = 0; i < 4; i++)
            send_beat(irna_pkg::OP_ALLOC, 0, 0, $urandom | 32'h1);
    endtask

    initial
    begin
        int i;
        for (i = 0; i < NODES; i++)
        begin
            tag_mem[i]  = '0;
            nxt_mem[i]  = 0;
            prv_mem[i]  = 0;
            links_ok[i] = 1'b0;
        end
        scan_pos   = 1;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = irna_pkg::OP_ALLOC;
        node_index = '0;
        root_index = '0;
        payload    = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        wait_drain();
        test_random_mix(500);
        wait_drain();
        test_table_full();
        wait_drain();
        test_random_mix((n_items < 1650) ? 1700 - n_items : 50);
        wait_drain();
        idle_on = 1'b0;
        test_random_mix(150);
        wait_drain();
        repeat (20) @(posedge clk);

        $display("run covered %0d beats: %0d allocates (%0d on a full table), %0d links,",
                 n_items, n_alloc, n_full, n_link);
        $display("%0d unlinks and %0d releases, with random idling on both channels",
                 n_unlink, n_release);
        if (errors == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
